>>> src/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// shared widths, codes and link types of the indexed lifo stack
// ----------------------------------------------------------------------------
package ils_pkg;

   localparam int DEPTH_DEFAULT = 128;
   localparam int WORD_W        = 32;
   localparam int FUNC_W        = 2;
   localparam int POS_W         = 8;
   localparam int STATUS_W      = 2;
   localparam int FILL_W        = 8;
   localparam int CAP_W         = 8;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 8'd128;

   localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_POS   = 2'd3;

   // shift command seen by every cell
   typedef struct packed {
      logic push;
      logic pop;
   } cell_cmd_type;

   // access token walking down the chain
   typedef struct packed {
      logic                     valid;
      logic                     wr;
      logic [POS_W-1:0]         slot;
      logic signed [WORD_W-1:0] value;
   } fwd_type;

   // result token walking back up the chain
   typedef struct packed {
      logic                     valid;
      logic signed [WORD_W-1:0] data;
   } ret_type;

endpackage

>>> src/ils_if.sv
// ----------------------------------------------------------------------------
// ils channel interfaces
// request, response and csr write channels of the indexed lifo stack
// ----------------------------------------------------------------------------
interface ils_req_if;
   logic                                valid;
   logic                                ready;
   logic [ils_pkg::FUNC_W-1:0]          func;
   logic signed [ils_pkg::WORD_W-1:0]   value;
   logic [ils_pkg::POS_W-1:0]           position;

   modport source (output valid, func, value, position, input ready);
   modport sink   (input valid, func, value, position, output ready);
endinterface

interface ils_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [ils_pkg::WORD_W-1:0]   data;
   logic [ils_pkg::STATUS_W-1:0]        status;
   logic [ils_pkg::FILL_W-1:0]          fill_count;

   modport source (output valid, data, status, fill_count, input ready);
   modport sink   (input valid, data, status, fill_count, output ready);
endinterface

interface ils_csr_if;
   logic                       valid;
   logic                       ready;
   logic [ils_pkg::CAP_W-1:0]  data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

>>> src/ils_cell.sv
// ----------------------------------------------------------------------------
// ils_cell
// one stack entry with its forward and return token stages
// ----------------------------------------------------------------------------
module ils_cell #(
   parameter int INDEX = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ils_pkg::cell_cmd_type             cmd,
   input  logic signed [ils_pkg::WORD_W-1:0] above_entry,
   input  logic signed [ils_pkg::WORD_W-1:0] below_entry,
   input  ils_pkg::fwd_type                  fwd_in,
   output ils_pkg::fwd_type                  fwd_out,
   input  ils_pkg::ret_type                  ret_below,
   output ils_pkg::ret_type                  ret_out,
   output logic signed [ils_pkg::WORD_W-1:0] entry_out
);

   logic signed [ils_pkg::WORD_W-1:0] entry_ff, entry_in;
   ils_pkg::fwd_type                  fwd_ff;
   ils_pkg::ret_type                  ret_ff, ret_in;
   logic                              hit;

   assign hit = fwd_ff.valid && (32'(fwd_ff.slot) == INDEX);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.push) begin
         entry_in = above_entry;
      end else if (cmd.pop) begin
         entry_in = below_entry;
      end else if (hit && fwd_ff.wr) begin
         entry_in = fwd_ff.value;
      end
   end

   always_comb begin
      ret_in = ret_below;
      if (hit) begin
         ret_in.valid = 1'b1;
         ret_in.data  = fwd_ff.wr ? fwd_ff.value : entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= '0;
         ret_ff <= '0;
      end else begin
         fwd_ff <= fwd_in;
         ret_ff <= ret_in;
      end
   end

   always_comb begin
      fwd_out       = fwd_ff;
      fwd_out.valid = fwd_ff.valid && !hit;
   end

   assign ret_out   = ret_ff;
   assign entry_out = entry_ff;

endmodule

>>> src/ils_chain.sv
// ----------------------------------------------------------------------------
// ils_chain
// row of stack cells, top of stack in cell 0
// ----------------------------------------------------------------------------
module ils_chain #(
   parameter int DEPTH = ils_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ils_pkg::cell_cmd_type             cmd,
   input  logic signed [ils_pkg::WORD_W-1:0] push_value,
   input  ils_pkg::fwd_type                  fwd_in,
   output ils_pkg::ret_type                  ret_out,
   output logic signed [ils_pkg::WORD_W-1:0] top_entry
);

   logic signed [ils_pkg::WORD_W-1:0] entry_w [DEPTH];
   logic signed [ils_pkg::WORD_W-1:0] above_w [DEPTH];
   logic signed [ils_pkg::WORD_W-1:0] below_w [DEPTH];
   ils_pkg::fwd_type                  fwd_w   [DEPTH+1];
   ils_pkg::ret_type                  ret_w   [DEPTH+1];

   assign fwd_w[0]     = fwd_in;
   assign ret_w[DEPTH] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_top
         assign above_w[i] = push_value;
      end else begin : g_mid
         assign above_w[i] = entry_w[i-1];
      end

      if (i == DEPTH-1) begin : g_bottom
         assign below_w[i] = entry_w[i];
      end else begin : g_inner
         assign below_w[i] = entry_w[i+1];
      end

      ils_cell #(.INDEX(i)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .above_entry (above_w[i]),
         .below_entry (below_w[i]),
         .fwd_in      (fwd_w[i]),
         .fwd_out     (fwd_w[i+1]),
         .ret_below   (ret_w[i+1]),
         .ret_out     (ret_w[i]),
         .entry_out   (entry_w[i])
      );
   end

   assign ret_out   = ret_w[0];
   assign top_entry = entry_w[0];

endmodule

>>> src/indexed_lifo_stack.sv
// ----------------------------------------------------------------------------
// indexed_lifo_stack
// lifo stack of signed words with peek and overwrite at a depth
// ----------------------------------------------------------------------------
// The stack is a row of DEPTH cells with the top entry in cell 0. Push and
// pop shift the whole row by one cell at once, and for these requests and
// every request that ends in an error the response is registered directly
// from the request. A read or overwrite at depth p sends a token down the
// row one cell per cycle and the result back up the same way; the response
// is registered once the result leaves cell 0. One request is in flight at a
// time; the next is taken only once the previous response has left the
// output register or leaves it in that same cycle. No clearing pass follows
// reset.
// ----------------------------------------------------------------------------
module indexed_lifo_stack #(
   parameter int DEPTH = ils_pkg::DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   ils_req_if.sink    req_bus,
   ils_rsp_if.source  rsp_bus,
   ils_csr_if.sink    csr_bus
);

   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int POS_W    = ils_pkg::POS_W;
   localparam int FILL_W   = ils_pkg::FILL_W;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type                         state_ff, state_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [ils_pkg::CAP_W-1:0]         capacity_ff, capacity_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [ils_pkg::WORD_W-1:0] rsp_data_ff, rsp_data_in;
   logic [ils_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [FILL_W-1:0]                 rsp_fill_ff, rsp_fill_in;

   ils_pkg::cell_cmd_type             cmd;
   ils_pkg::fwd_type                  fwd;
   ils_pkg::ret_type                  ret;
   logic signed [ils_pkg::WORD_W-1:0] top_entry;
   logic [31:0]                       limit;
   logic                              accept;

   ils_chain #(.DEPTH(DEPTH)) u_chain (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .push_value (req_bus.value),
      .fwd_in     (fwd),
      .ret_out    (ret),
      .top_entry  (top_entry)
   );

   assign limit = (32'(capacity_ff) < 32'(DEPTH)) ? 32'(capacity_ff) : 32'(DEPTH);
   assign req_bus.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      capacity_in   = capacity_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fill_in   = rsp_fill_ff;
      cmd           = '0;
      fwd           = '0;

      if (csr_bus.valid) begin
         capacity_in = csr_bus.data;
      end

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '0;
               rsp_status_in = ils_pkg::STATUS_OK;
               rsp_fill_in   = FILL_W'(count_ff);
               case (req_bus.func)
                  ils_pkg::FUNC_PUSH: begin
                     if (32'(count_ff) >= limit) begin
                        rsp_status_in = ils_pkg::STATUS_OVERFLOW;
                     end else begin
                        cmd.push    = 1'b1;
                        count_in    = count_ff + CNT_W'(1);
                        rsp_data_in = req_bus.value;
                        rsp_fill_in = FILL_W'(count_ff + CNT_W'(1));
                     end
                  end
                  ils_pkg::FUNC_POP: begin
                     if (count_ff == '0) begin
                        rsp_status_in = ils_pkg::STATUS_UNDERFLOW;
                     end else begin
                        cmd.pop     = 1'b1;
                        count_in    = count_ff - CNT_W'(1);
                        rsp_data_in = top_entry;
                        rsp_fill_in = FILL_W'(count_ff - CNT_W'(1));
                     end
                  end
                  default: begin
                     if (req_bus.position == '0 ||
                         32'(req_bus.position) > 32'(count_ff)) begin
                        rsp_status_in = ils_pkg::STATUS_BAD_POS;
                     end else begin
                        rsp_valid_in = 1'b0;
                        fwd.valid    = 1'b1;
                        fwd.wr       = (req_bus.func == ils_pkg::FUNC_WRITE);
                        fwd.slot     = req_bus.position - POS_W'(1);
                        fwd.value    = req_bus.value;
                        state_in     = ST_WALK;
                     end
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (ret.valid) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = ret.data;
               rsp_status_in = ils_pkg::STATUS_OK;
               rsp_fill_in   = FILL_W'(count_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         capacity_ff  <= ils_pkg::CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.data       = rsp_data_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.fill_count = rsp_fill_ff;

endmodule

>>> src/ils_check.sv
// ----------------------------------------------------------------------------
// ils_check
// port level checks of the indexed lifo stack, bound to the top level
// ----------------------------------------------------------------------------
module ils_check (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [ils_pkg::FUNC_W-1:0]        req_func,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [ils_pkg::WORD_W-1:0] rsp_data,
   input logic [ils_pkg::STATUS_W-1:0]      rsp_status,
   input logic [ils_pkg::FILL_W-1:0]        rsp_fill_count
);

   // response held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // errors return a zero word
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ils_pkg::STATUS_OK |-> rsp_data == '0)
      else $error("error response with nonzero data");

   // underflow only from an empty stack
   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ils_pkg::STATUS_UNDERFLOW |-> rsp_fill_count == '0)
      else $error("underflow with entries held");

   // push and pop answer on the next cycle
   a_shift_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (req_func == ils_pkg::FUNC_PUSH || req_func == ils_pkg::FUNC_POP)
      |=> rsp_valid)
      else $error("push or pop response late");

endmodule

bind indexed_lifo_stack ils_check u_ils_check (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .req_func       (req_bus.func),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_data       (rsp_bus.data),
   .rsp_status     (rsp_bus.status),
   .rsp_fill_count (rsp_bus.fill_count)
);

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the indexed lifo stack
// ----------------------------------------------------------------------------
// A short directed run covers the empty and full stack, the extreme words,
// every request kind and the bad depth cases, including a capacity of zero
// and a capacity dropped below the fill count. Random phases follow: each
// one sets a capacity and then runs a fill stretch and a drain stretch. The
// settings include a capacity above the stack size, which drives the stack
// to full. A scoreboard predicts each response when its request is accepted
// and compares the responses in order. Both channels idle at random. The
// response side holds off once for a long stretch so that the stack stalls
// its request input.
// ----------------------------------------------------------------------------
module tb;

   localparam int          WORD_W       = ils_pkg::WORD_W;
   localparam int          FUNC_W       = ils_pkg::FUNC_W;
   localparam int          POS_W        = ils_pkg::POS_W;
   localparam int          STATUS_W     = ils_pkg::STATUS_W;
   localparam int          FILL_W       = ils_pkg::FILL_W;
   localparam int          CAP_W        = ils_pkg::CAP_W;
   localparam int          STACK_DEPTH  = ils_pkg::DEPTH_DEFAULT;
   localparam int          CYCLE_LIMIT  = 1000000;
   localparam int          DRAIN_CYCLES = 2 * STACK_DEPTH + 40;
   localparam int          HOLD_AT      = 150;
   localparam int          HOLD_CYCLES  = 200;
   localparam int unsigned CALM_FROM    = 330;
   localparam int unsigned CALM_TO      = 450;

   typedef struct packed {
      logic signed [WORD_W-1:0] data;
      logic [STATUS_W-1:0]      status;
      logic [FILL_W-1:0]        fill_count;
   } stack_result_type;

   class scoreboard_type;
      logic signed [WORD_W-1:0] words [STACK_DEPTH];
      int unsigned              held;
      logic [CAP_W-1:0]         capacity;
      stack_result_type         awaited[$];
      int                       errors;
      int                       checked;
      int                       status_seen [4];

      function void clear();
         held     = 0;
         capacity = ils_pkg::CAPACITY_RESET;
         errors   = 0;
         checked  = 0;
         awaited.delete();
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void set_capacity(input logic [CAP_W-1:0] cap);
         capacity = cap;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void note_request(input logic [FUNC_W-1:0] func,
                                 input logic signed [WORD_W-1:0] value,
                                 input logic [POS_W-1:0] position);
         stack_result_type r;
         int unsigned      limit;
         int unsigned      slot;
         limit = (capacity < STACK_DEPTH) ? capacity : STACK_DEPTH;
         r.data   = '0;
         r.status = ils_pkg::STATUS_OK;
         case (func)
            ils_pkg::FUNC_PUSH: begin
               if (held >= limit) begin
                  r.status = ils_pkg::STATUS_OVERFLOW;
               end else begin
                  words[held] = value;
                  held++;
                  r.data = value;
               end
            end
            ils_pkg::FUNC_POP: begin
               if (held == 0) begin
                  r.status = ils_pkg::STATUS_UNDERFLOW;
               end else begin
                  held--;
                  r.data = words[held];
               end
            end
            default: begin
               if (position == 0 || position > held) begin
                  r.status = ils_pkg::STATUS_BAD_POS;
               end else begin
                  slot = held - position;
                  if (func == ils_pkg::FUNC_WRITE) words[slot] = value;
                  r.data = words[slot];
               end
            end
         endcase
         r.fill_count = held[FILL_W-1:0];
         awaited.push_back(r);
      endfunction

      function void check_response(input logic signed [WORD_W-1:0] data,
                                   input logic [STATUS_W-1:0] status,
                                   input logic [FILL_W-1:0] fill_count);
         stack_result_type e;
         if (awaited.size() == 0) begin
            $display("%0t: response with none awaited: expected none, %s",
                     $time, "got the following");
            $display("%0t:    data %0d status %0d fill %0d",
                     $time, data, status, fill_count);
            errors++;
            return;
         end
         e = awaited.pop_front();
         checked++;
         status_seen[status]++;
         if (data !== e.data) begin
            $display("%0t: data: expected %0d, got %0d", $time, e.data, data);
            errors++;
         end
         if (status !== e.status) begin
            $display("%0t: status: expected %0d, got %0d", $time, e.status, status);
            errors++;
         end
         if (fill_count !== e.fill_count) begin
            $display("%0t: fill_count: expected %0d, got %0d", $time, e.fill_count, fill_count);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   ils_req_if req_bus ();
   ils_rsp_if rsp_bus ();
   ils_csr_if csr_bus ();

   indexed_lifo_stack dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   scoreboard_type  book;
   int unsigned     sent;
   int unsigned     got;
   int unsigned     cap_writes;
   int              cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic bit sender_idle();
      if (sent >= CALM_FROM && sent < CALM_TO) return 1'b0;
      return $urandom_range(99) < 11;
   endfunction

   function automatic logic [FUNC_W-1:0] pick_func(input bit filling);
      int unsigned r;
      r = $urandom_range(99);
      if (filling) begin
         if (r < 75) return ils_pkg::FUNC_PUSH;
         if (r < 80) return ils_pkg::FUNC_POP;
      end else begin
         if (r < 10) return ils_pkg::FUNC_PUSH;
         if (r < 70) return ils_pkg::FUNC_POP;
      end
      return (r % 2 == 0) ? ils_pkg::FUNC_READ : ils_pkg::FUNC_WRITE;
   endfunction

   function automatic logic [POS_W-1:0] pick_depth(input int unsigned held);
      int unsigned r;
      r = $urandom_range(99);
      if (held == 0 || r < 10) return POS_W'($urandom_range(255));
      if (r < 15) return POS_W'($urandom_range(held, 1));
      return POS_W'($urandom_range((held < 8) ? held : 8, 1));
   endfunction

   task automatic send_req(input logic [FUNC_W-1:0] func,
                           input logic signed [WORD_W-1:0] value,
                           input logic [POS_W-1:0] position);
      while (sender_idle()) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.func     <= func;
      req_bus.value    <= value;
      req_bus.position <= position;
      do @(posedge clock); while (!req_bus.ready);
      book.note_request(func, value, position);
      sent++;
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      req_bus.valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= cap;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      book.set_capacity(cap);
      cap_writes++;
   endtask

   task automatic run_phase(input logic [CAP_W-1:0] cap, input int n_fill,
                            input int n_drain);
      write_capacity(cap);
      for (int i = 0; i < n_fill + n_drain; i++) begin
         send_req(pick_func(i < n_fill), $urandom(), pick_depth(book.held));
      end
   endtask

   // response side: random idling, one long hold-off
   initial begin
      int  hold_left;
      bit  held_off;
      hold_left = 0;
      held_off  = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            book.check_response(rsp_bus.data, rsp_bus.status, rsp_bus.fill_count);
            got++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!held_off && got == HOLD_AT) begin
            held_off  = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else if (got >= CALM_FROM && got < CALM_TO) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= 11);
         end
      end
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles", cycles);
      $display("indexed_lifo_stack: mismatch");
      $finish;
   end

   initial begin
      book = new();
      book.clear();
      sent       = 0;
      got        = 0;
      cap_writes = 0;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.func     <= ils_pkg::FUNC_PUSH;
      req_bus.value    <= '0;
      req_bus.position <= '0;
      csr_bus.valid    <= 1'b0;
      csr_bus.data     <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty stack
      send_req(ils_pkg::FUNC_POP,   32'sd0, 8'd0);
      send_req(ils_pkg::FUNC_READ,  $urandom(), 8'd0);
      send_req(ils_pkg::FUNC_WRITE, $urandom(), 8'd1);
      // extreme words
      send_req(ils_pkg::FUNC_PUSH,  32'sh7fffffff, 8'hff);
      send_req(ils_pkg::FUNC_PUSH,  32'sh80000000, 8'd0);
      send_req(ils_pkg::FUNC_PUSH,  -32'sd1, 8'd0);
      send_req(ils_pkg::FUNC_PUSH,  32'sd0, 8'd1);
      send_req(ils_pkg::FUNC_READ,  32'sd0, 8'd1);
      send_req(ils_pkg::FUNC_READ,  -32'sd1, 8'd4);
      send_req(ils_pkg::FUNC_READ,  32'sd0, 8'd5);
      send_req(ils_pkg::FUNC_READ,  32'sd0, 8'hff);
      send_req(ils_pkg::FUNC_WRITE, 32'sh55555555, 8'd2);
      send_req(ils_pkg::FUNC_WRITE, 32'shaaaaaaaa, 8'd4);
      send_req(ils_pkg::FUNC_READ,  32'sd0, 8'd2);
      send_req(ils_pkg::FUNC_WRITE, 32'sd1, 8'd0);
      // capacity dropped below the fill count
      write_capacity(8'd2);
      send_req(ils_pkg::FUNC_PUSH,  32'sd7, 8'd0);
      repeat (3) send_req(ils_pkg::FUNC_POP, 32'sd0, 8'd0);
      send_req(ils_pkg::FUNC_PUSH,  32'sd9, 8'd0);
      send_req(ils_pkg::FUNC_PUSH,  32'sd11, 8'd0);
      // zero capacity
      write_capacity(8'd0);
      send_req(ils_pkg::FUNC_PUSH,  32'sd3, 8'd0);
      repeat (3) send_req(ils_pkg::FUNC_POP, 32'sd0, 8'd0);
      send_req(ils_pkg::FUNC_PUSH,  32'sd5, 8'd0);

      run_phase(8'd255, 200, 100);
      run_phase(CAP_W'($urandom_range(40, 1)), 40, 80);
      run_phase(8'd0, 15, 25);
      run_phase(8'd1, 30, 30);
      run_phase(8'd128, 60, 60);

      req_bus.valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests, %0d responses checked over %0d capacity settings",
               sent, book.checked, cap_writes);
      $display("status: ok %0d, overflow %0d, underflow %0d, bad depth %0d",
               book.status_seen[ils_pkg::STATUS_OK],
               book.status_seen[ils_pkg::STATUS_OVERFLOW],
               book.status_seen[ils_pkg::STATUS_UNDERFLOW],
               book.status_seen[ils_pkg::STATUS_BAD_POS]);
      if (book.errors == 0 && book.pending() == 0) begin
         $display("indexed_lifo_stack: match");
      end else begin
         $display("indexed_lifo_stack: mismatch");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/ils_pkg.sv
src/ils_if.sv
src/ils_cell.sv
src/ils_chain.sv
src/indexed_lifo_stack.sv
src/ils_check.sv
verif/tb.sv
